>>> rtl/core/assert_macros.svh
// Assertion helper macros for the scheduler checker.
// Included by the checker file; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MLFQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mlfq_pkg.sv
// Shared types and codes of the feedback queue scheduler.
// No dependencies; used by every other file of the block but assert_macros.svh.
package mlfq_pkg;

  localparam int ID_W     = 8;
  localparam int WORK_W   = 16;
  localparam int STATUS_W = 3;
  localparam int LVL_W    = 2;
  localparam int ENTRY_W  = ID_W + WORK_W;
  localparam int CFG_IDX_W = 2;

  // request op codes
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REQUEUED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 2'd2;

  localparam logic [WORK_W-1:0] QUANTUM0_RST = 16'd2;
  localparam logic [WORK_W-1:0] QUANTUM1_RST = 16'd4;
  localparam logic [WORK_W-1:0] QUANTUM2_RST = 16'd8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic [LVL_W-1:0]    served_level;
    logic [WORK_W-1:0]   slice_length;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch request, launch memory read
    logic commit;   // apply queue update, load response register
  } ctl_cmd_t;

endpackage

>>> rtl/core/mlfq_if.sv
// Request and response channel interfaces of the scheduler.
// Depends on mlfq_pkg for field widths.
interface mlfq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [mlfq_pkg::ID_W-1:0]     task_id;
  logic [mlfq_pkg::WORK_W-1:0]   burst_length;

  modport source (output valid, op, task_id, burst_length, input ready);
  modport sink   (input valid, op, task_id, burst_length, output ready);
endinterface

interface mlfq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mlfq_pkg::STATUS_W-1:0] status;
  logic [mlfq_pkg::ID_W-1:0]     served_id;
  logic [mlfq_pkg::LVL_W-1:0]    served_level;
  logic [mlfq_pkg::WORK_W-1:0]   slice_length;

  modport source (output valid, status, served_id, served_level, slice_length, input ready);
  modport sink   (input valid, status, served_id, served_level, slice_length, output ready);
endinterface

>>> rtl/core/mlfq_ctrl.sv
// Scheduler controller: two-state sequencer and response valid flag.
// Depends on mlfq_pkg.
module mlfq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output mlfq_pkg::ctl_cmd_t cmd
);
  import mlfq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready   = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  // commit only when the response slot is free or draining this cycle
  assign cmd.commit  = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.capture) state_next = S_EXEC;
      S_EXEC: if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> rtl/core/mlfq_dp.sv
// Scheduler datapath: task memory, ring pointers, level pick, slice math.
// Depends on mlfq_pkg; driven by commands from mlfq_ctrl.
module mlfq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVELS      = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mlfq_pkg::ctl_cmd_t              cmd,
  input  logic                            cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlfq_pkg::WORK_W-1:0]     cfg_data,
  input  logic                            op,
  input  logic [mlfq_pkg::ID_W-1:0]       task_id,
  input  logic [mlfq_pkg::WORK_W-1:0]     burst_length,
  output mlfq_pkg::rsp_t                  rsp
);
  import mlfq_pkg::*;

  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int SW        = PW + 2;
  localparam int MEM_DEPTH = LEVELS << PW;
  localparam int AW        = $clog2(MEM_DEPTH);

  // state
  logic [PW-1:0]      level_head  [LEVELS];
  logic [CW-1:0]      level_count [LEVELS];
  logic [PW-1:0]      level_head_next  [LEVELS];
  logic [CW-1:0]      level_count_next [LEVELS];
  logic [LVL_W-1:0]   pass_level;
  logic [LVL_W-1:0]   pass_level_next;
  logic [WORK_W-1:0]  quantum [3];
  logic [ENTRY_W-1:0] mem [MEM_DEPTH];

  // latched request
  logic               op_q;
  logic [ID_W-1:0]    id_q;
  logic [WORK_W-1:0]  burst_q;
  logic [LVL_W-1:0]   lvl_q;
  logic               empty_q;
  logic [ENTRY_W-1:0] rd_data;

  // pick
  logic               found;
  logic [LVL_W-1:0]   pick;
  logic [AW-1:0]      rd_addr;

  // commit path
  logic               wr_en;
  logic [LVL_W-1:0]   wr_lvl;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [WORK_W-1:0]  cur_quantum;
  logic [WORK_W-1:0]  slice;
  logic [WORK_W-1:0]  rem_new;
  logic [LVL_W-1:0]   nxt_lvl;
  logic [LVL_W-1:0]   dest;
  logic               requeue;
  logic               full0;
  rsp_t               rsp_next;

  function automatic logic [PW-1:0] ring_tail(input logic [PW-1:0] h,
                                              input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] h);
    return (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + PW'(1);
  endfunction

  // circular scan from pass_level for the first non-empty level
  always_comb begin
    logic [2:0] idx;
    found = 1'b0;
    pick  = '0;
    for (int k = 0; k < LEVELS; k++) begin
      idx = 3'(pass_level) + 3'(k);
      if (idx >= 3'(LEVELS)) idx = idx - 3'(LEVELS);
      if (!found && level_count[idx[LVL_W-1:0]] != '0) begin
        found = 1'b1;
        pick  = idx[LVL_W-1:0];
      end
    end
  end

  assign rd_addr = AW'({pick, level_head[pick]});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      id_q    <= task_id;
      burst_q <= burst_length;
      lvl_q   <= pick;
      empty_q <= !found;
    end
  end

  // task memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    case (lvl_q)
      2'd0:    cur_quantum = quantum[0];
      2'd1:    cur_quantum = quantum[1];
      default: cur_quantum = quantum[2];
    endcase
  end

  assign slice   = (rd_data[WORK_W-1:0] < cur_quantum) ? rd_data[WORK_W-1:0] : cur_quantum;
  assign rem_new = rd_data[WORK_W-1:0] - slice;
  assign requeue = (rem_new != '0);
  assign nxt_lvl = lvl_q + LVL_W'(1);
  assign full0   = (level_count[0] == CW'(QUEUE_DEPTH));

  // demote one level unless last level or target full
  always_comb begin
    dest = lvl_q;
    if (nxt_lvl < LVL_W'(LEVELS)) begin
      if (level_count[nxt_lvl] != CW'(QUEUE_DEPTH)) dest = nxt_lvl;
    end
  end

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      level_head_next[l]  = level_head[l];
      level_count_next[l] = level_count[l];
    end
    pass_level_next = pass_level;
    wr_en           = 1'b0;
    wr_lvl          = '0;
    wr_data         = {id_q, burst_q};
    rsp_next        = '0;

    if (cmd.commit) begin
      if (op_q == OP_ADD) begin
        rsp_next.served_id = id_q;
        if (full0) begin
          rsp_next.status = ST_REJECTED;
        end else begin
          rsp_next.status     = ST_ADDED;
          wr_en               = 1'b1;
          level_count_next[0] = level_count[0] + CW'(1);
        end
      end else if (empty_q) begin
        rsp_next.status = ST_IDLE;
        pass_level_next = '0;
      end else begin
        rsp_next.served_id    = rd_data[ENTRY_W-1:WORK_W];
        rsp_next.served_level = lvl_q;
        rsp_next.slice_length = slice;
        level_head_next[lvl_q] = ring_inc(level_head[lvl_q]);
        pass_level_next = (nxt_lvl == LVL_W'(LEVELS)) ? '0 : nxt_lvl;
        if (requeue) begin
          rsp_next.status = ST_REQUEUED;
          wr_en           = 1'b1;
          wr_lvl          = dest;
          wr_data         = {rd_data[ENTRY_W-1:WORK_W], rem_new};
          if (dest != lvl_q) begin
            level_count_next[lvl_q] = level_count[lvl_q] - CW'(1);
            level_count_next[dest]  = level_count[dest] + CW'(1);
          end
        end else begin
          rsp_next.status         = ST_FINISHED;
          level_count_next[lvl_q] = level_count[lvl_q] - CW'(1);
        end
      end
    end
  end

  // tail from pre-update pointers; also right for a same-level requeue
  assign wr_addr = AW'({wr_lvl, ring_tail(level_head[wr_lvl], level_count[wr_lvl])});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        level_head[l]  <= '0;
        level_count[l] <= '0;
      end
      pass_level <= '0;
      quantum[0] <= QUANTUM0_RST;
      quantum[1] <= QUANTUM1_RST;
      quantum[2] <= QUANTUM2_RST;
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        level_head[l]  <= level_head_next[l];
        level_count[l] <= level_count_next[l];
      end
      pass_level <= pass_level_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM0: quantum[0] <= cfg_data;
          CFG_QUANTUM1: quantum[1] <= cfg_data;
          CFG_QUANTUM2: quantum[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= rsp_next;
  end

endmodule

>>> rtl/core/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg, mlfq_if, mlfq_ctrl and mlfq_dp.
//
//   port       dir   handshake      content
//   req        in    valid/ready    op, task_id, burst_length
//   rsp        out   valid/ready    status, served_id, served_level, slice_length
//   cfg_*      in    write enable   quantum_level0..2 by index
//
// Each request is first captured, which also reads the head task from the
// task memory; the rings are then updated and the response register loaded.
// The update waits for the registered read of that memory.
// A held response stalls the update cycle; a new request is taken as soon
// as the previous one is committed, even while its response waits.
// Reset is synchronous, clears pointers, counts and pass level, and reloads
// the default quanta; task memory is undefined until written, never cleared.
module multilevel_feedback_queue_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVELS      = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfq_pkg::WORK_W-1:0]    cfg_data,
  mlfq_req_if.sink                       req,
  mlfq_rsp_if.source                     rsp
);
  import mlfq_pkg::*;

  ctl_cmd_t cmd;
  rsp_t     rsp_data;

  // sequencer: idle/exec and response valid
  mlfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // queues, pick, slice arithmetic and response register
  mlfq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVELS      (LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (req.op),
    .task_id      (req.task_id),
    .burst_length (req.burst_length),
    .rsp          (rsp_data)
  );

  assign rsp.status       = rsp_data.status;
  assign rsp.served_id    = rsp_data.served_id;
  assign rsp.served_level = rsp_data.served_level;
  assign rsp.slice_length = rsp_data.slice_length;

endmodule

>>> rtl/core/mlfq_chk.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on mlfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlfq_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [mlfq_pkg::STATUS_W-1:0] status,
  input logic [mlfq_pkg::ID_W-1:0]     served_id,
  input logic [mlfq_pkg::LVL_W-1:0]    served_level,
  input logic [mlfq_pkg::WORK_W-1:0]   slice_length
);
  import mlfq_pkg::*;

  `MLFQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `MLFQ_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable({status, served_id, served_level, slice_length}), "response changed while stalled")
  `MLFQ_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "second request taken while one is in flight")
  `MLFQ_ASSERT_NEXT(a_rsp_follows, clk, rst, req_valid && req_ready ##1 (!rsp_valid || rsp_ready), rsp_valid, "no response after accepted request")
  `MLFQ_ASSERT_IMPLY(a_idle_zero, clk, rst, rsp_valid && status == ST_IDLE, served_id == '0 && served_level == '0 && slice_length == '0, "idle response has nonzero fields")

endmodule

bind multilevel_feedback_queue_scheduler mlfq_chk u_mlfq_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .served_id    (rsp.served_id),
  .served_level (rsp.served_level),
  .slice_length (rsp.slice_length)
);
